@@ hw/rtl/kpq_pkg.sv @@
// kpq_pkg: shared constants for the keypad hold qualifier
// widths of the key pins, hold counters, key codes and event ring
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kpq_pkg;

    localparam int NUM_KEYS   = 6;
    localparam int KEY_CODE_W = 3;
    localparam int HOLD_W     = 8;
    // ring depth must be a power of two so the pointers wrap on their own
    localparam int RING_DEPTH = 32;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = HOLD_W'(30);

endpackage : kpq_pkg

`default_nettype wire

@@ hw/rtl/keypad_hold_qualifier_with_fifo.sv @@
// keypad_hold_qualifier_with_fifo: key hold qualification and key-code event ring
// one input register, one processing pass, one result register
// depends on kpq_pkg
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------------------
//  input    | i_in_valid / o_in_ready       | i_pin_levels, i_tick, i_take
//  result   | o_out_valid / i_out_ready     | o_key_valid, o_key_code, o_held_mask,
//           |                               | o_queue_count
//  config   | i_cfg_we (no wait)            | i_cfg_wdata (hold_ticks)
//
// one request per clock sustained while results are taken; a request is held in the input
// register, and the pass runs from the input register into the result register.
// all counters, pushes into the ring and the pop resolve in that single pass.
// i_rst_n is synchronous active low; it clears control state, hold_ticks goes to 30.
// a stalled result holds the pass; the input register still takes one request.
`timescale 1ns / 1ps
`default_nettype none

module keypad_hold_qualifier_with_fifo
    import kpq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_we,
    input  wire logic [HOLD_W-1:0]     i_cfg_wdata,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [NUM_KEYS-1:0]   i_pin_levels,
    input  wire logic                  i_tick,
    input  wire logic                  i_take,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_key_valid,
    output logic [KEY_CODE_W-1:0]      o_key_code,
    output logic [NUM_KEYS-1:0]        o_held_mask,
    output logic [RING_AW-1:0]         o_queue_count
);

    logic [HOLD_W-1:0]      r_hold_ticks;

    // input register
    logic                   r_in_valid;
    logic [NUM_KEYS-1:0]    r_pins;
    logic                   r_tick;
    logic                   r_take;

    // block state
    logic [NUM_KEYS-1:0]    r_pressed, n_pressed;
    logic [HOLD_W-1:0]      r_cnt [NUM_KEYS];
    logic [HOLD_W-1:0]      n_cnt [NUM_KEYS];
    logic [KEY_CODE_W-1:0]  r_ring [RING_DEPTH];
    logic [RING_AW-1:0]     r_head, n_head;
    logic [RING_AW-1:0]     r_tail, n_tail;

    // result register
    logic                   r_out_valid;
    logic                   r_key_valid, n_key_valid;
    logic [KEY_CODE_W-1:0]  r_key_code, n_key_code;
    logic [NUM_KEYS-1:0]    r_held_mask;
    logic [RING_AW-1:0]     r_count, n_count;

    logic                   advance;
    logic [NUM_KEYS-1:0]    push_we;
    logic [RING_AW-1:0]     push_addr [NUM_KEYS];
    logic [KEY_CODE_W-1:0]  rd_code;
    logic                   pop;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_pressed = r_pressed;
        n_head    = r_head;
        push_we   = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            n_cnt[i]     = r_cnt[i];
            push_addr[i] = '0;
        end

        // countdown and pushes, keys in ascending order
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (r_tick && (r_cnt[i] != '0)) begin
                n_cnt[i] = r_cnt[i] - HOLD_W'(1);
                if ((n_cnt[i] == '0) && ((n_head + RING_AW'(1)) != r_tail)) begin
                    push_we[i]   = 1'b1;
                    push_addr[i] = n_head;
                    n_head       = n_head + RING_AW'(1);
                end
            end
        end

        // pin sampling, active low
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (!r_pins[i]) begin
                if (!r_pressed[i]) begin
                    n_pressed[i] = 1'b1;
                    n_cnt[i]     = r_hold_ticks;
                end
            end else if (r_pressed[i]) begin
                n_pressed[i] = 1'b0;
                n_cnt[i]     = '0;
            end
        end

        // tail entry may be written in this same pass when the ring was empty
        rd_code = r_ring[r_tail];
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (push_we[i] && (push_addr[i] == r_tail)) begin
                rd_code = KEY_CODE_W'(i);
            end
        end

        pop         = r_take && (n_head != r_tail);
        n_tail      = pop ? (r_tail + RING_AW'(1)) : r_tail;
        n_key_valid = pop;
        n_key_code  = pop ? rd_code : '0;
        n_count     = n_head - n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_TICKS_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pins <= i_pin_levels;
            r_tick <= i_tick;
            r_take <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (advance) begin
            r_pressed <= n_pressed;
            r_head    <= n_head;
            r_tail    <= n_tail;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // ring entries, no reset: only entries between tail and head are read
    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (push_we[i]) begin
                    r_ring[push_addr[i]] <= KEY_CODE_W'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_key_valid <= n_key_valid;
            r_key_code  <= n_key_code;
            r_held_mask <= n_pressed;
            r_count     <= n_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_valid   = r_key_valid;
    assign o_key_code    = r_key_code;
    assign o_held_mask   = r_held_mask;
    assign o_queue_count = r_count;

endmodule : keypad_hold_qualifier_with_fifo

`default_nettype wire
